// ----- src/bpot_pkg.sv -----
// ============================================================================
// bpot_pkg: shared types and constants for the box pair opening test
// Decision codes, register indexes, reset values and parameter defaults.
// ============================================================================
package bpot_pkg;

    // Parameter defaults
    localparam int COORD_BITS_DEF      = 32;
    localparam int ANGLE_FRAC_BITS_DEF = 12;

    // Fixed widths of the opening angle and its square
    localparam int ANGLE_W  = 16;
    localparam int ANGLE2_W = 2 * ANGLE_W;

    // Register file: four registers, one index each
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OPEN_ANGLE          = 2'd0,
        REG_CUTOFF_ENABLE       = 2'd1,
        REG_CUTOFF_RADIUS       = 2'd2,
        REG_NEIGHBOUR_THRESHOLD = 2'd3
    } reg_idx_t;

    // Register reset values (theta 0.5, threshold about 0.0001)
    localparam logic [ANGLE_W-1:0] OPEN_ANGLE_RST    = 16'd2048;
    localparam int                 NEIGHBOUR_THR_RST = 105;

    // Result codes
    typedef enum logic [1:0] {
        DEC_OPEN    = 2'd0,
        DEC_ACCEPT  = 2'd1,
        DEC_DISCARD = 2'd2
    } decision_t;

endpackage

// ----- src/box_pair_opening_test.sv -----
// ============================================================================
// box_pair_opening_test: multipole acceptance test for one pair of tree boxes
// Six-stage pipeline that answers open, accept or discard for each item.
// ============================================================================
// The block takes one box-pair item per clock while in_stall is low and
// returns one decision per item, in order. The six register stages (absolute
// offsets and width sums, gaps, squares, sums of squares, split products with
// theta squared, final compare) all advance together; a stall on the output
// freezes the whole pipeline and raises in_stall in the same cycle, so nothing
// is lost or repeated. The user must write the registers over the APB port
// only while no item is in flight; the block itself does not enforce this.
module box_pair_opening_test
    import bpot_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [((COORD_BITS - 1 > 32) ? 3 : 2) + REG_IDX_W - 1:0] paddr,
    input  logic [((COORD_BITS - 1 > 32) ? 64 : 32) - 1:0]          pwdata,
    output logic [((COORD_BITS - 1 > 32) ? 64 : 32) - 1:0]          prdata,
    output logic                              pready,

    // Input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [COORD_BITS-2:0]             width_i_x,
    input  logic [COORD_BITS-2:0]             width_i_y,
    input  logic [COORD_BITS-2:0]             width_i_z,
    input  logic [COORD_BITS-2:0]             width_j_x,
    input  logic [COORD_BITS-2:0]             width_j_y,
    input  logic [COORD_BITS-2:0]             width_j_z,
    input  logic signed [COORD_BITS-1:0]      dist_x,
    input  logic signed [COORD_BITS-1:0]      dist_y,
    input  logic signed [COORD_BITS-1:0]      dist_z,

    // Output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        decision
);

    localparam int C        = COORD_BITS;
    localparam int WID_W    = C - 1;
    localparam int DATA_W   = (WID_W > 32) ? 64 : 32;
    localparam int ADDR_LSB = (WID_W > 32) ? 3 : 2;
    localparam int GAP_W    = C + 1;
    localparam int GSUM_W   = C + 3;
    localparam int SQG_W    = 2 * GAP_W;
    localparam int DM_W     = SQG_W + 2;
    localparam int SQD_W    = 2 * C;
    localparam int DD_W     = SQD_W + 2;
    localparam int R2_W     = 2 * C;
    localparam int LHS_W    = 2 * C + 2 * ANGLE_FRAC_BITS;
    localparam int LO_W     = DD_W / 2;
    localparam int HI_W     = DD_W - LO_W;
    localparam int RHS_W    = ANGLE2_W + DD_W;
    localparam int CMP_W    = RHS_W + 2 * ANGLE_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] open_angle_reg;
    logic               cutoff_enable_reg;
    logic [WID_W-1:0]   cutoff_radius_reg;
    logic [WID_W-1:0]   neighbour_thr_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_LSB + REG_IDX_W - 1:ADDR_LSB]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_angle_reg    <= OPEN_ANGLE_RST;
            cutoff_enable_reg <= 1'b0;
            cutoff_radius_reg <= '0;
            neighbour_thr_reg <= WID_W'(NEIGHBOUR_THR_RST);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_OPEN_ANGLE:          open_angle_reg    <= pwdata[ANGLE_W-1:0];
                REG_CUTOFF_ENABLE:       cutoff_enable_reg <= pwdata[0];
                REG_CUTOFF_RADIUS:       cutoff_radius_reg <= pwdata[WID_W-1:0];
                REG_NEIGHBOUR_THRESHOLD: neighbour_thr_reg <= pwdata[WID_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            REG_OPEN_ANGLE:          prdata = DATA_W'(open_angle_reg);
            REG_CUTOFF_ENABLE:       prdata = DATA_W'(cutoff_enable_reg);
            REG_CUTOFF_RADIUS:       prdata = DATA_W'(cutoff_radius_reg);
            REG_NEIGHBOUR_THRESHOLD: prdata = DATA_W'(neighbour_thr_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Constants derived from the registers, refreshed every cycle
    // ------------------------------------------------------------------
    logic [ANGLE2_W-1:0] theta2_reg;
    logic [R2_W-1:0]     rad2x4_reg;
    logic [R2_W-1:0]     rad2_reg;

    always_ff @(posedge clk)
    begin
        theta2_reg <= ANGLE2_W'(open_angle_reg) * ANGLE2_W'(open_angle_reg);
        rad2x4_reg <= R2_W'({cutoff_radius_reg, 1'b0}) * R2_W'({cutoff_radius_reg, 1'b0});
        rad2_reg   <= R2_W'(cutoff_radius_reg) * R2_W'(cutoff_radius_reg);
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages advance unless the output item stalls
    // ------------------------------------------------------------------
    logic advance;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;

    assign advance  = !(s6_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: width sums and absolute offsets per axis
    // ------------------------------------------------------------------
    logic [WID_W-1:0] wi [3];
    logic [WID_W-1:0] wj [3];
    logic [C-1:0]     dv [3];
    logic [C-1:0]     s1_wsum_reg [3];
    logic [C-1:0]     s1_mag_reg  [3];

    assign wi[0] = width_i_x;
    assign wi[1] = width_i_y;
    assign wi[2] = width_i_z;
    assign wj[0] = width_j_x;
    assign wj[1] = width_j_y;
    assign wj[2] = width_j_z;
    assign dv[0] = dist_x;
    assign dv[1] = dist_y;
    assign dv[2] = dist_z;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s1_wsum_reg[a] <= C'(wi[a]) + C'(wj[a]);
                // most negative offset wraps to its exact magnitude
                s1_mag_reg[a]  <= dv[a][C-1] ? (~dv[a] + C'(1)) : dv[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: doubled gaps clamped at zero, largest width sum
    // ------------------------------------------------------------------
    logic [GAP_W-1:0] s2_gap_reg [3];
    logic [C-1:0]     s2_mag_reg [3];
    logic [C-1:0]     s2_wmax_reg;
    logic [C-1:0]     wmax_next;

    always_comb
    begin
        wmax_next = s1_wsum_reg[0];
        if (s1_wsum_reg[1] > wmax_next)
            wmax_next = s1_wsum_reg[1];
        if (s1_wsum_reg[2] > wmax_next)
            wmax_next = s1_wsum_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if ({s1_mag_reg[a], 1'b0} > GAP_W'(s1_wsum_reg[a]))
                    s2_gap_reg[a] <= {s1_mag_reg[a], 1'b0} - GAP_W'(s1_wsum_reg[a]);
                else
                    s2_gap_reg[a] <= '0;
                s2_mag_reg[a] <= s1_mag_reg[a];
            end
            s2_wmax_reg <= wmax_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares, gap sum and neighbour test
    // ------------------------------------------------------------------
    logic [SQG_W-1:0] s3_gsq_reg [3];
    logic [SQD_W-1:0] s3_dsq_reg [3];
    logic [SQD_W-1:0] s3_wsq_reg;
    logic             s3_nbr_reg;
    logic [GSUM_W-1:0] gapsum;

    assign gapsum = GSUM_W'(s2_gap_reg[0]) + GSUM_W'(s2_gap_reg[1])
                  + GSUM_W'(s2_gap_reg[2]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s3_gsq_reg[a] <= SQG_W'(s2_gap_reg[a]) * SQG_W'(s2_gap_reg[a]);
                s3_dsq_reg[a] <= SQD_W'(s2_mag_reg[a]) * SQD_W'(s2_mag_reg[a]);
            end
            s3_wsq_reg <= SQD_W'(s2_wmax_reg) * SQD_W'(s2_wmax_reg);
            s3_nbr_reg <= gapsum < GSUM_W'({neighbour_thr_reg, 1'b0});
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sums of squares, scaled width term
    // ------------------------------------------------------------------
    logic [DM_W-1:0]  s4_dm4_reg;
    logic [DD_W-1:0]  s4_dd2_reg;
    logic [LHS_W-1:0] s4_lhs_reg;
    logic             s4_nbr_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_dm4_reg <= DM_W'(s3_gsq_reg[0]) + DM_W'(s3_gsq_reg[1])
                        + DM_W'(s3_gsq_reg[2]);
            s4_dd2_reg <= DD_W'(s3_dsq_reg[0]) + DD_W'(s3_dsq_reg[1])
                        + DD_W'(s3_dsq_reg[2]);
            s4_lhs_reg <= LHS_W'(s3_wsq_reg) << (2 * ANGLE_FRAC_BITS);
            s4_nbr_reg <= s3_nbr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: cutoff compares, theta squared times offset split in halves
    // ------------------------------------------------------------------
    logic [ANGLE2_W+LO_W-1:0] s5_pp_lo_reg;
    logic [ANGLE2_W+HI_W-1:0] s5_pp_hi_reg;
    logic [LHS_W-1:0]         s5_lhs_reg;
    logic                     s5_nbr_reg;
    logic                     s5_disc_reg;
    logic                     s5_far_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_pp_lo_reg <= (ANGLE2_W + LO_W)'(theta2_reg)
                          * (ANGLE2_W + LO_W)'(s4_dd2_reg[LO_W-1:0]);
            s5_pp_hi_reg <= (ANGLE2_W + HI_W)'(theta2_reg)
                          * (ANGLE2_W + HI_W)'(s4_dd2_reg[DD_W-1:LO_W]);
            s5_disc_reg  <= s4_dm4_reg >= DM_W'(rad2x4_reg);
            s5_far_reg   <= s4_dd2_reg > DD_W'(rad2_reg);
            s5_lhs_reg   <= s4_lhs_reg;
            s5_nbr_reg   <= s4_nbr_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: join the halves, angle compare, pick the decision
    // ------------------------------------------------------------------
    logic [RHS_W-1:0] rhs;
    logic             accept_hit;
    decision_t        decision_next;
    decision_t        s6_decision_reg;

    assign rhs        = (RHS_W'(s5_pp_hi_reg) << LO_W) + RHS_W'(s5_pp_lo_reg);
    assign accept_hit = CMP_W'(s5_lhs_reg) < CMP_W'(rhs);

    always_comb
    begin
        if (s5_nbr_reg)
            decision_next = DEC_OPEN;
        else if (cutoff_enable_reg && s5_disc_reg)
            decision_next = DEC_DISCARD;
        else if (cutoff_enable_reg && s5_far_reg)
            decision_next = DEC_OPEN;
        else if (accept_hit)
            decision_next = DEC_ACCEPT;
        else
            decision_next = DEC_OPEN;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s6_decision_reg <= decision_next;
    end

    assign out_valid = s6_valid_reg;
    assign decision  = s6_decision_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_decision_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (decision == DEC_OPEN || decision == DEC_ACCEPT
                       || decision == DEC_DISCARD))
        else $error("unused decision code on output");

    a_discard_needs_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && decision == DEC_DISCARD) |-> cutoff_enable_reg)
        else $error("discard given with cutoff disabled");

    a_accept_needs_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && decision == DEC_ACCEPT) |-> (open_angle_reg != '0))
        else $error("accept given with zero opening angle");

    a_neighbour_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && s5_nbr_reg && advance) |=> (decision == DEC_OPEN))
        else $error("neighbour pair not opened");

endmodule
